// ===== src/psat_pkg.sv =====
// types and widths shared by the separating-axis overlap core
// no dependencies; used by psat_cell, psat_axis_gen and the top level
`default_nettype none

package psat_pkg;

    // coordinate, edge component and projection widths (fixed by the Q15.4 format)
    localparam int unsigned COORD_W = 20;
    localparam int unsigned AXIS_W  = 21;
    localparam int unsigned PROD_W  = 41;
    localparam int unsigned PROJ_W  = 42;

    // one axis travelling down the cell chain with its running intervals
    typedef struct packed {
        logic                      valid;
        logic signed [AXIS_W-1:0]  ax;
        logic signed [AXIS_W-1:0]  ay;
        logic                      has_a;
        logic signed [PROJ_W-1:0]  lo_a;
        logic signed [PROJ_W-1:0]  hi_a;
        logic                      has_b;
        logic signed [PROJ_W-1:0]  lo_b;
        logic signed [PROJ_W-1:0]  hi_b;
    } psat_token_t;

endpackage

`default_nettype wire

// ===== src/polygon_overlap_separating_axis_core.sv =====
// top level of the separating-axis overlap core: load control, cell chain and
// result register; uses psat_pkg, psat_axis_gen and psat_cell
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  input    | in        | in_valid/in_stall  | poly_select, vertex_x, vertex_y, last_vertex
//  output   | out       | out_valid/out_stall| overlap, vertices_dropped
//
// loading takes one vertex per cycle while in_stall is low; the last vertex of B starts the test
// the result is registered once every axis has left the cell chain: the edge walker
// reads each polygon's vertices and then its first vertex again to close it, and each
// edge axis passes the two-stage cells and the register stages around them
// in_stall stays high from the start of the test until its result is registered;
// the result register waits for out_stall to drop while loading of the next pair goes on
// reset clears counts, flags and all valid bits; the vertex store needs no clearing
`default_nettype none

module polygon_overlap_separating_axis_core
    import psat_pkg::*;
#(
    parameter int unsigned MAX_POLY_VERTICES = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      poly_select,
    input  wire logic signed [COORD_W-1:0] vertex_x,
    input  wire logic signed [COORD_W-1:0] vertex_y,
    input  wire logic                      last_vertex,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           overlap,
    output logic                           vertices_dropped
);

    localparam int unsigned NCELL = 2 * MAX_POLY_VERTICES;
    localparam int unsigned IDX_W = $clog2(NCELL);
    localparam int unsigned CNT_W = $clog2(MAX_POLY_VERTICES + 1);
    localparam int unsigned TOT_W = $clog2(NCELL + 1);

    localparam logic S_LOAD = 1'b0;
    localparam logic S_TEST = 1'b1;

    logic              state_reg;
    logic [CNT_W-1:0]  cnt_a_reg;
    logic [CNT_W-1:0]  cnt_b_reg;
    logic              ovf_reg;
    logic              sep_reg;
    logic [TOT_W-1:0]  done_cnt_reg;
    logic              out_valid_reg;
    logic              overlap_reg;
    logic              dropped_reg;
    logic              accept;
    logic              full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              start;
    logic              finished;
    logic              can_emit;
    logic              tail_sep;
    logic [NCELL-1:0]  active;
    psat_token_t       tok [NCELL+1];

    // input transfer and store write
    assign in_stall = (state_reg != S_LOAD);
    assign accept   = in_valid && !in_stall;
    assign full     = poly_select ? (cnt_b_reg == CNT_W'(MAX_POLY_VERTICES))
                                  : (cnt_a_reg == CNT_W'(MAX_POLY_VERTICES));
    assign wr_en    = accept && !full;
    assign wr_addr  = poly_select ? (IDX_W'(MAX_POLY_VERTICES) + IDX_W'(cnt_b_reg))
                                  : IDX_W'(cnt_a_reg);
    assign start    = accept && poly_select && last_vertex;

    // end of test: every axis has left the chain
    assign finished = (state_reg == S_TEST)
                   && (done_cnt_reg == (TOT_W'(cnt_a_reg) + TOT_W'(cnt_b_reg)));
    assign can_emit = !out_valid_reg || !out_stall;
    assign tail_sep = tok[NCELL].valid && tok[NCELL].has_a && tok[NCELL].has_b
                   && ((tok[NCELL].hi_a < tok[NCELL].lo_b) || (tok[NCELL].hi_b < tok[NCELL].lo_a));

    // control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            sep_reg       <= 1'b0;
            done_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            overlap_reg   <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            if (finished && can_emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (full)
                            ovf_reg <= 1'b1;
                        else if (poly_select)
                            cnt_b_reg <= cnt_b_reg + CNT_W'(1);
                        else
                            cnt_a_reg <= cnt_a_reg + CNT_W'(1);
                        if (start)
                            state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (tok[NCELL].valid)
                    begin
                        done_cnt_reg <= done_cnt_reg + TOT_W'(1);
                        if (tail_sep)
                            sep_reg <= 1'b1;
                    end
                    if (finished && can_emit)
                    begin
                        overlap_reg   <= (cnt_a_reg != '0) && (cnt_b_reg != '0) && !sep_reg;
                        dropped_reg   <= ovf_reg;
                        cnt_a_reg     <= '0;
                        cnt_b_reg     <= '0;
                        ovf_reg       <= 1'b0;
                        sep_reg       <= 1'b0;
                        done_cnt_reg  <= '0;
                        state_reg     <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // axis source
    psat_axis_gen #(
        .MAX_POLY_VERTICES(MAX_POLY_VERTICES)
    ) u_axis_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_x    (vertex_x),
        .wr_y    (vertex_y),
        .start   (start),
        .cnt_a   (cnt_a_reg),
        .cnt_b   (cnt_b_reg),
        .head    (tok[0])
    );

    // chain of vertex cells, A's slots first
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        if (k < MAX_POLY_VERTICES)
        begin : g_a
            assign active[k] = (CNT_W'(k) < cnt_a_reg);
        end
        else
        begin : g_b
            assign active[k] = (CNT_W'(k - MAX_POLY_VERTICES) < cnt_b_reg);
        end

        psat_cell #(
            .IS_B(k >= MAX_POLY_VERTICES)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en && (wr_addr == IDX_W'(k))),
            .wr_x    (vertex_x),
            .wr_y    (vertex_y),
            .active  (active[k]),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    assign out_valid        = out_valid_reg;
    assign overlap          = overlap_reg;
    assign vertices_dropped = dropped_reg;

endmodule

`default_nettype wire

// ===== src/psat_cell.sv =====
// one vertex cell of the projection chain: holds a vertex, projects each passing
// axis onto it and folds the result into the interval of its polygon; uses psat_pkg
`default_nettype none

module psat_cell
    import psat_pkg::*;
#(
    parameter bit IS_B = 1'b0
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic signed [COORD_W-1:0]  wr_x,
    input  wire logic signed [COORD_W-1:0]  wr_y,
    input  wire logic                       active,
    input  wire psat_token_t                tok_in,
    output psat_token_t                     tok_out
);

    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [PROD_W-1:0]  prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_next;
    logic                      act_s1_reg;
    psat_token_t               tok_s1_reg;
    psat_token_t               tok_out_reg;
    psat_token_t               tok_out_next;
    logic signed [PROJ_W-1:0]  proj;

    // vertex storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
    end

    // stage one: the two products
    assign prod_x_next = x_reg * tok_in.ax;
    assign prod_y_next = y_reg * tok_in.ay;

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        act_s1_reg <= active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_s1_reg  <= '0;
            tok_out_reg <= '0;
        end
        else
        begin
            tok_s1_reg  <= tok_in;
            tok_out_reg <= tok_out_next;
        end
    end

    // stage two: sum and min/max update
    assign proj = {prod_x_reg[PROD_W-1], prod_x_reg} + {prod_y_reg[PROD_W-1], prod_y_reg};

    always_comb
    begin
        tok_out_next = tok_s1_reg;
        if (tok_s1_reg.valid && act_s1_reg)
        begin
            if (IS_B)
            begin
                if (!tok_s1_reg.has_b || (proj < tok_s1_reg.lo_b))
                    tok_out_next.lo_b = proj;
                if (!tok_s1_reg.has_b || (proj > tok_s1_reg.hi_b))
                    tok_out_next.hi_b = proj;
                tok_out_next.has_b = 1'b1;
            end
            else
            begin
                if (!tok_s1_reg.has_a || (proj < tok_s1_reg.lo_a))
                    tok_out_next.lo_a = proj;
                if (!tok_s1_reg.has_a || (proj > tok_s1_reg.hi_a))
                    tok_out_next.hi_a = proj;
                tok_out_next.has_a = 1'b1;
            end
        end
    end

    assign tok_out = tok_out_reg;

endmodule

`default_nettype wire

// ===== src/psat_axis_gen.sv =====
// vertex memory and edge walker: turns the stored polygons into a stream of
// edge-normal axes, A's edges first, then B's; uses psat_pkg
`default_nettype none

module psat_axis_gen
    import psat_pkg::*;
#(
    parameter int unsigned MAX_POLY_VERTICES = 32
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   wr_en,
    input  wire logic [$clog2(2*MAX_POLY_VERTICES)-1:0] wr_addr,
    input  wire logic signed [COORD_W-1:0]              wr_x,
    input  wire logic signed [COORD_W-1:0]              wr_y,
    input  wire logic                                   start,
    input  wire logic [$clog2(MAX_POLY_VERTICES+1)-1:0] cnt_a,
    input  wire logic [$clog2(MAX_POLY_VERTICES+1)-1:0] cnt_b,
    output psat_token_t                                 head
);

    localparam int unsigned DEPTH = 2 * MAX_POLY_VERTICES;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(MAX_POLY_VERTICES + 1);

    logic [2*COORD_W-1:0]      mem [DEPTH];
    logic                      running_reg;
    logic                      poly_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          n_cur;
    logic                      wrap;
    logic [IDX_W-1:0]          rd_addr;
    logic                      rd_v_reg;
    logic                      rd_first_reg;
    logic signed [COORD_W-1:0] rd_x_reg;
    logic signed [COORD_W-1:0] rd_y_reg;
    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    psat_token_t               head_reg;
    psat_token_t               head_next;

    // read address: vertex idx of the current polygon, back to vertex 0 to close it
    assign n_cur   = poly_reg ? cnt_b : cnt_a;
    assign wrap    = (idx_reg == n_cur);
    assign rd_addr = (poly_reg ? IDX_W'(MAX_POLY_VERTICES) : IDX_W'(0))
                   + (wrap ? IDX_W'(0) : IDX_W'(idx_reg));

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {wr_x, wr_y};
        {rd_x_reg, rd_y_reg} <= mem[rd_addr];
    end

    // walk sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            poly_reg     <= 1'b0;
            idx_reg      <= '0;
            rd_v_reg     <= 1'b0;
            rd_first_reg <= 1'b0;
            head_reg     <= '0;
        end
        else
        begin
            rd_v_reg     <= running_reg;
            rd_first_reg <= (idx_reg == '0);
            head_reg     <= head_next;
            if (start)
            begin
                running_reg <= 1'b1;
                poly_reg    <= 1'b0;
                idx_reg     <= '0;
            end
            else if (running_reg)
            begin
                if (wrap)
                begin
                    idx_reg <= '0;
                    if (poly_reg)
                        running_reg <= 1'b0;
                    else
                        poly_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
        end
    end

    // previous vertex of the walk
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
    end

    // edge normal (-dy, dx) from previous to current vertex
    always_comb
    begin
        head_next       = '0;
        head_next.valid = rd_v_reg && !rd_first_reg;
        head_next.ax    = {prev_y_reg[COORD_W-1], prev_y_reg} - {rd_y_reg[COORD_W-1], rd_y_reg};
        head_next.ay    = {rd_x_reg[COORD_W-1], rd_x_reg} - {prev_x_reg[COORD_W-1], prev_x_reg};
    end

    assign head = head_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_polygon_overlap_separating_axis_core.sv =====
// testbench for the separating-axis overlap core: directed and random polygon pairs
// depends on psat_pkg and polygon_overlap_separating_axis_core
`default_nettype none

class overlap_scoreboard;
    localparam int NV = 32;
    logic signed [19:0] poly_x [2][NV];
    logic signed [19:0] poly_y [2][NV];
    int                 cnt [2];
    bit                 dropped;
    bit                 exp_overlap [$];
    bit                 exp_dropped [$];
    int                 errors;

    function new();
        cnt[0] = 0;
        cnt[1] = 0;
        dropped = 0;
        errors = 0;
    endfunction

    // projection interval of polygon p onto axis (ax, ay)
    function void poly_interval(int p, longint ax, longint ay, output longint lo,
                                output longint hi);
        longint v;
        for (int i = 0; i < cnt[p]; i++)
        begin
            v = longint'(poly_x[p][i]) * ax + longint'(poly_y[p][i]) * ay;
            if (i == 0 || v < lo) lo = v;
            if (i == 0 || v > hi) hi = v;
        end
    endfunction

    function bit edges_separate(int p);
        longint dx, dy, lo0, hi0, lo1, hi1;
        int     j;
        for (int i = 0; i < cnt[p]; i++)
        begin
            j = (i + 1 == cnt[p]) ? 0 : i + 1;
            dx = longint'(poly_x[p][j]) - longint'(poly_x[p][i]);
            dy = longint'(poly_y[p][j]) - longint'(poly_y[p][i]);
            poly_interval(0, -dy, dx, lo0, hi0);
            poly_interval(1, -dy, dx, lo1, hi1);
            if (hi0 < lo1 || hi1 < lo0) return 1;
        end
        return 0;
    endfunction

    // note an accepted vertex transfer
    function void note_vertex(bit sel, logic signed [19:0] x, logic signed [19:0] y,
                              bit last);
        if (cnt[sel] < NV)
        begin
            poly_x[sel][cnt[sel]] = x;
            poly_y[sel][cnt[sel]] = y;
            cnt[sel]++;
        end
        else
            dropped = 1;
        if (sel && last)
        begin
            if (cnt[0] == 0 || cnt[1] == 0)
                exp_overlap.push_back(0);
            else
                exp_overlap.push_back(!edges_separate(0) && !edges_separate(1));
            exp_dropped.push_back(dropped);
            cnt[0] = 0;
            cnt[1] = 0;
            dropped = 0;
        end
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(bit ov, bit dr);
        bit eo, ed;
        if (exp_overlap.size() == 0)
        begin
            $display("%0t: unexpected result overlap=%0b dropped=%0b", $time, ov, dr);
            errors++;
            return;
        end
        eo = exp_overlap.pop_front();
        ed = exp_dropped.pop_front();
        if (eo != ov)
        begin
            $display("%0t: overlap expected %0b actual %0b", $time, eo, ov);
            errors++;
        end
        if (ed != dr)
        begin
            $display("%0t: vertices_dropped expected %0b actual %0b", $time, ed, dr);
            errors++;
        end
    endfunction
endclass

module tb_polygon_overlap_separating_axis_core;
    timeunit 1ns;
    timeprecision 1ps;
    import psat_pkg::*;

    logic                      clk = 0;
    logic                      rst_n = 0;
    logic                      in_valid = 0;
    logic                      in_stall;
    logic                      poly_select = 0;
    logic signed [COORD_W-1:0] vertex_x = '0;
    logic signed [COORD_W-1:0] vertex_y = '0;
    logic                      last_vertex = 0;
    logic                      out_valid;
    logic                      out_stall = 0;
    logic                      overlap;
    logic                      vertices_dropped;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    overlap_scoreboard sb = new();

    polygon_overlap_separating_axis_core i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .poly_select(poly_select), .vertex_x(vertex_x), .vertex_y(vertex_y),
        .last_vertex(last_vertex), .out_valid(out_valid), .out_stall(out_stall),
        .overlap(overlap), .vertices_dropped(vertices_dropped)
    );

    always #2 clk = ~clk;

    // receiver: random stall and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(overlap, vertices_dropped);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // one vertex transfer, with random idle cycles before it
    task automatic send_vertex(bit sel, logic signed [19:0] x, logic signed [19:0] y,
                               bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        poly_select <= sel;
        vertex_x <= x;
        vertex_y <= y;
        last_vertex <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_vertex(sel, x, y, last);
        items_sent++;
    endtask

    // random coordinate: mostly near a center, sometimes full range
    function automatic logic signed [19:0] rand_coord(int center, int span);
        if ($urandom_range(9) == 0) return 20'($urandom);
        return 20'(center + $signed($urandom_range(2 * span)) - span);
    endfunction

    // regular-ish convex polygon around a center, or random points near it when noisy
    task automatic send_poly(bit sel, int n, int cx, int cy, int r, bit noisy);
        real ang;
        int  x, y;
        for (int i = 0; i < n; i++)
        begin
            ang = 6.2831853 * i / n;
            x = cx + $rtoi(r * $cos(ang));
            y = cy + $rtoi(r * $sin(ang));
            if (noisy) begin x = rand_coord(cx, r); y = rand_coord(cy, r); end
            send_vertex(sel, 20'(x), 20'(y), (i == n - 1));
        end
    endtask

    task automatic random_pair();
        int n0, n1, cx, cy, r0, r1, k;
        bit noisy;
        k = $urandom_range(99);
        n0 = (k < 3) ? $urandom_range(33, 36) : $urandom_range(1, 8);
        n1 = (k > 96) ? $urandom_range(33, 36) : $urandom_range(1, 8);
        if (k == 50) n0 = 0;
        r0 = $urandom_range(1, 2000);
        r1 = $urandom_range(1, 2000);
        cx = $signed($urandom_range(3 * (r0 + r1))) - (r0 + r1);
        cy = $signed($urandom_range(3 * (r0 + r1))) - (r0 + r1);
        noisy = ($urandom_range(9) == 0);
        if (n0 > 0) send_poly(0, n0, 0, 0, r0, noisy);
        send_poly(1, n1, cx, cy, r1, noisy);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (sb.exp_overlap.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: overlapping squares, separated squares, extremes
        send_poly(0, 4, 0, 0, 100, 0);
        send_poly(1, 4, 50, 0, 100, 0);
        send_poly(0, 4, 0, 0, 100, 0);
        send_poly(1, 4, 1000, 0, 100, 0);
        send_vertex(0, 20'sh80000, 20'sh80000, 0);
        send_vertex(0, 20'sh7FFFF, 20'sh80000, 0);
        send_vertex(0, 20'sh7FFFF, 20'sh7FFFF, 1);
        send_vertex(1, 20'sh80000, 20'sh7FFFF, 0);
        send_vertex(1, 20'sh7FFFF, 20'sh7FFFF, 1);
        // empty first polygon, degenerate single points, last flag on A mid-polygon
        send_vertex(1, 5, 5, 1);
        send_vertex(0, 7, 7, 1);
        send_vertex(0, 7, 7, 0);
        send_vertex(1, 7, 7, 1);
        // store full on both polygons, with a dropped last vertex of B
        send_poly(0, 34, 0, 0, 500, 0);
        send_poly(1, 33, 100, 0, 500, 0);
        wait_drained();

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                3: begin send_idle_pct = 23; recv_stall_pct = 23; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            while (items_sent < 380 * (ph + 1)) random_pair();
            // hold off until all results are in
            wait_drained();
        end

        if (sb.errors == 0 && sb.exp_overlap.size() == 0)
            $display("polygon_overlap_separating_axis_core test passed");
        else
            $display("polygon_overlap_separating_axis_core test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("polygon_overlap_separating_axis_core test failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== polygon_overlap_separating_axis_core.f =====
src/psat_pkg.sv
src/psat_cell.sv
src/psat_axis_gen.sv
src/polygon_overlap_separating_axis_core.sv
tb/sv/tb_polygon_overlap_separating_axis_core.sv
